// File: rtl/core/cwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwm_pkg
// Shared types and constants of the cylindrical inverse warp address unit.
// ----------------------------------------------------------------------------
package cwm_pkg;

  localparam int Q_FRAC   = 30;   // fraction bits of angle, sin and cos
  localparam int A_W      = 31;   // angle below a right angle, Q30
  localparam int A2_W     = 32;   // angle squared, Q30
  localparam int TERM_W   = 31;   // series term
  localparam int SUM_W    = 36;   // signed running sums
  localparam int YQ_W     = 65;   // |height| * radius
  localparam int UC_W     = 31;   // positive cosine, up to 2^30
  localparam int QB       = 26;   // quotient bits kept; larger values saturate anyway
  localparam int NX_W     = 47;   // radius * sin
  localparam int OUT_W    = 24;
  localparam int CFG_W    = 21;
  localparam int N_TERMS  = 12;
  localparam int DIV_SHIFT = 43;  // reciprocal scale for division by constant
  localparam int RECIP_W  = 43;
  localparam int RLO_W    = 22;   // low slice of the reciprocal

  localparam logic [A_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [SUM_W-1:0] C_ONE = SUM_W'(64'd1 << Q_FRAC);
  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    REG_RADIUS,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_INV_SCALE,
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic                     vld;
    logic                     aneg;
    logic                     hneg;
    logic                     big;
    logic [YQ_W-1:0]          yq;
    logic [A2_W-1:0]          a2;
    logic [TERM_W-1:0]        ts;
    logic [TERM_W-1:0]        tc;
    logic signed [SUM_W-1:0]  s;
    logic signed [SUM_W-1:0]  c;
  } tay_tok_t;

  typedef struct packed {
    logic             vld;
    logic             sat;
    logic             aneg;
    logic             hneg;
    logic             ovx;
    logic             ovy;
    logic [UC_W-1:0]  uc;
    logic [UC_W-1:0]  rx;
    logic [QB-1:0]    lx;
    logic [UC_W-1:0]  ry;
    logic [QB-1:0]    ly;
  } div_tok_t;

endpackage

// File: rtl/core/cwm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwm_if
// Valid/ready channels: output pixel position in, source position out.
// ----------------------------------------------------------------------------
interface cwm_in_if #(parameter int COORD_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_col;
  logic [COORD_BITS-1:0] out_row;

  modport source (output valid, output out_col, output out_row, input ready);
  modport sink (input valid, input out_col, input out_row, output ready);
endinterface

interface cwm_out_if ();
  logic               valid;
  logic               ready;
  logic signed [23:0] src_x;
  logic signed [23:0] src_y;
  logic               inside_res;

  modport source (output valid, output src_x, output src_y, output inside_res, input ready);
  modport sink (input valid, input src_x, input src_y, input inside_res, output ready);
endinterface

// File: rtl/core/cwm_taylor_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwm_taylor_cell
// One sin/cos series term: multiply by a^2, divide by constant, accumulate.
// ----------------------------------------------------------------------------
module cwm_taylor_cell
  import cwm_pkg::*;
#(
  parameter int K = 1
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  tay_tok_t tok_i,
  output tay_tok_t tok_o
);

  localparam int N_W    = 33;
  localparam int P_W    = TERM_W + A2_W;
  localparam int PLO_W  = N_W + RLO_W;
  localparam int PHI_W  = N_W + RECIP_W - RLO_W;
  localparam int FULL_W = N_W + RECIP_W;
  localparam logic [63:0] DS = 64'(2 * K * (2 * K + 1));
  localparam logic [63:0] DC = 64'((2 * K - 1) * (2 * K));
  localparam logic [63:0] MS = ((64'd1 << DIV_SHIFT) + DS - 64'd1) / DS;
  localparam logic [63:0] MC = ((64'd1 << DIV_SHIFT) + DC - 64'd1) / DC;
  localparam bit ADD_TERM = (K % 2) == 0;

  tay_tok_t st1_r, st2_r, st3_r, st3_nxt;
  logic [N_W-1:0]   ns_r, nc_r;
  logic [PLO_W-1:0] pps_lo_r, ppc_lo_r, pps_lo_nxt, ppc_lo_nxt;
  logic [PHI_W-1:0] pps_hi_r, ppc_hi_r, pps_hi_nxt, ppc_hi_nxt;
  logic [P_W-1:0]   ps, pc;
  logic [FULL_W-1:0] fs, fc;
  logic [TERM_W-1:0] qs, qc;

  // term * a^2, then drop the Q30 fraction
  assign ps = tok_i.ts * tok_i.a2;
  assign pc = tok_i.tc * tok_i.a2;

  // exact floor division by constant: n * ceil(2^43 / d) >> 43, in two slices
  assign pps_lo_nxt = ns_r * MS[RLO_W-1:0];
  assign pps_hi_nxt = ns_r * MS[RECIP_W-1:RLO_W];
  assign ppc_lo_nxt = nc_r * MC[RLO_W-1:0];
  assign ppc_hi_nxt = nc_r * MC[RECIP_W-1:RLO_W];

  assign fs = {pps_hi_r, {RLO_W{1'b0}}} + FULL_W'(pps_lo_r);
  assign fc = {ppc_hi_r, {RLO_W{1'b0}}} + FULL_W'(ppc_lo_r);
  assign qs = fs[DIV_SHIFT +: TERM_W];
  assign qc = fc[DIV_SHIFT +: TERM_W];

  always_comb begin
    st3_nxt    = st2_r;
    st3_nxt.ts = qs;
    st3_nxt.tc = qc;
    if (ADD_TERM) begin
      st3_nxt.s = st2_r.s + SUM_W'(qs);
      st3_nxt.c = st2_r.c + SUM_W'(qc);
    end else begin
      st3_nxt.s = st2_r.s - SUM_W'(qs);
      st3_nxt.c = st2_r.c - SUM_W'(qc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r.vld <= 1'b0;
      st2_r.vld <= 1'b0;
      st3_r.vld <= 1'b0;
    end else if (en) begin
      st1_r    <= tok_i;
      ns_r     <= ps[Q_FRAC +: N_W];
      nc_r     <= pc[Q_FRAC +: N_W];
      st2_r    <= st1_r;
      pps_lo_r <= pps_lo_nxt;
      pps_hi_r <= pps_hi_nxt;
      ppc_lo_r <= ppc_lo_nxt;
      ppc_hi_r <= ppc_hi_nxt;
      st3_r    <= st3_nxt;
    end
  end

  assign tok_o = st3_r;

  // cosine series never climbs above one
  a_cos_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    st3_r.vld |-> st3_r.c <= C_ONE)
    else $error("cosine partial sum above one");

endmodule

// File: rtl/core/cwm_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwm_div_cell
// One restoring division step for the column and row quotients.
// ----------------------------------------------------------------------------
module cwm_div_cell
  import cwm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  div_tok_t tok_i,
  output div_tok_t tok_o
);

  div_tok_t tok_r, tok_nxt;
  logic [UC_W:0] tx, ty;
  logic          bx, by;

  assign tx = {tok_i.rx, tok_i.lx[QB-1]};
  assign ty = {tok_i.ry, tok_i.ly[QB-1]};
  assign bx = tx >= {1'b0, tok_i.uc};
  assign by = ty >= {1'b0, tok_i.uc};

  always_comb begin
    tok_nxt    = tok_i;
    tok_nxt.rx = bx ? UC_W'(tx - {1'b0, tok_i.uc}) : tx[UC_W-1:0];
    tok_nxt.ry = by ? UC_W'(ty - {1'b0, tok_i.uc}) : ty[UC_W-1:0];
    // numerator bits shift out the top, quotient bits in at the bottom
    tok_nxt.lx = {tok_i.lx[QB-2:0], bx};
    tok_nxt.ly = {tok_i.ly[QB-2:0], by};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

  a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
    tok_r.vld && !tok_r.sat && !tok_r.ovx |-> tok_r.rx < tok_r.uc)
    else $error("column remainder not below divisor");

  a_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
    tok_r.vld && !tok_r.sat && !tok_r.ovy |-> tok_r.ry < tok_r.uc)
    else $error("row remainder not below divisor");

endmodule

// File: rtl/core/cylinder_inverse_warp_map_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylinder_inverse_warp_map_unit
// Maps a cylindrical panorama pixel to its source image position.
// ----------------------------------------------------------------------------
// Fully pipelined: one word in and one word out per clock while the output
// word is taken (3 input stages, 12 series cells of 3 stages for sin and cos,
// 2 setup stages, 26 one-bit divider cells, 1 output register). The whole
// pipeline holds while the output word is not taken; ready follows that
// stall. The registers may be written only while no word is in flight.
// ----------------------------------------------------------------------------
module cylinder_inverse_warp_map_unit
  import cwm_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  cwm_in_if.sink           in_if,
  cwm_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int CF_W   = COORD_BITS + FRAC_BITS;
  localparam int DX_W   = ((CF_W > 20) ? CF_W : 20) + 2;
  localparam int DM_W   = DX_W - 1;
  localparam int AM_W   = DM_W + 20;
  localparam int AQ_W   = AM_W + 14 - FRAC_BITS;
  localparam int YP_W   = AM_W + 16;
  localparam int NXS_W  = NX_W + FRAC_BITS;
  localparam int HX_W   = NXS_W - QB;
  localparam int HXC_W  = (HX_W > UC_W) ? HX_W : UC_W;
  localparam int NY_W   = YQ_W + 14;
  localparam int HY_W   = NY_W - QB;
  localparam int X_W    = 29;

  // configuration
  logic [15:0]        radius_r;
  logic [19:0]        center_x_r, center_y_r, inv_scale_r;
  logic signed [20:0] offset_x_r, offset_y_r;
  logic [12:0]        src_width_r, src_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= 16'd1000;
      center_x_r   <= '0;
      center_y_r   <= '0;
      offset_x_r   <= '0;
      offset_y_r   <= '0;
      inv_scale_r  <= 20'h10000;
      src_width_r  <= 13'd4096;
      src_height_r <= 13'd4096;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_RADIUS:     radius_r     <= cfg_wdata[15:0];
        REG_CENTER_X:   center_x_r   <= cfg_wdata[19:0];
        REG_CENTER_Y:   center_y_r   <= cfg_wdata[19:0];
        REG_OFFSET_X:   offset_x_r   <= cfg_wdata;
        REG_OFFSET_Y:   offset_y_r   <= cfg_wdata;
        REG_INV_SCALE:  inv_scale_r  <= cfg_wdata[19:0];
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata[12:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata[12:0];
      endcase
    end
  end

  logic pipe_en;
  logic out_vld_r;
  assign pipe_en     = !out_vld_r || out_if.ready;
  assign in_if.ready = pipe_en;

  // stage 1: offsets and magnitudes
  logic signed [DX_W-1:0] dx, dy;
  logic [DM_W-1:0] p1_amag_r, p1_dmag_r;
  logic            p1_vld_r, p1_aneg_r, p1_hneg_r;

  assign dx = $signed(DX_W'({in_if.out_col, {FRAC_BITS{1'b0}}})) - DX_W'(offset_x_r);
  assign dy = $signed(DX_W'({in_if.out_row, {FRAC_BITS{1'b0}}})) - DX_W'(offset_y_r);

  // stage 2: scale to angle and height
  logic [AM_W-1:0] amul, hmul;
  logic [AQ_W-1:0] p2_aq_r;
  logic [AM_W-1:0] p2_hmag_r;
  logic            p2_vld_r, p2_aneg_r, p2_hneg_r;

  assign amul = p1_amag_r * inv_scale_r;
  assign hmul = p1_dmag_r * inv_scale_r;

  // stage 3: a^2 and |h| * radius, seed the series
  logic [A_W-1:0]    ang;
  logic [2*A_W-1:0]  asq;
  logic [YP_W-1:0]   yprod;
  tay_tok_t          t0_r;

  assign ang   = p2_aq_r[A_W-1:0];
  assign asq   = ang * ang;
  assign yprod = p2_hmag_r * radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      t0_r.vld <= 1'b0;
    end else if (pipe_en) begin
      p1_vld_r  <= in_if.valid;
      p1_aneg_r <= dx[DX_W-1];
      p1_hneg_r <= dy[DX_W-1];
      p1_amag_r <= dx[DX_W-1] ? DM_W'(-dx) : DM_W'(dx);
      p1_dmag_r <= dy[DX_W-1] ? DM_W'(-dy) : DM_W'(dy);

      p2_vld_r  <= p1_vld_r;
      p2_aneg_r <= p1_aneg_r;
      p2_hneg_r <= p1_hneg_r;
      p2_aq_r   <= {amul, {(14 - FRAC_BITS){1'b0}}};
      p2_hmag_r <= hmul;

      t0_r.vld  <= p2_vld_r;
      t0_r.aneg <= p2_aneg_r;
      t0_r.hneg <= p2_hneg_r;
      t0_r.big  <= p2_aq_r >= AQ_W'(HALF_PI_Q30);
      t0_r.yq   <= YQ_W'(yprod);
      t0_r.a2   <= asq[Q_FRAC +: A2_W];
      t0_r.ts   <= ang;
      t0_r.tc   <= TERM_W'(C_ONE);
      t0_r.s    <= SUM_W'(ang);
      t0_r.c    <= C_ONE;
    end
  end

  // series cells
  tay_tok_t tay_q [N_TERMS+1];
  assign tay_q[0] = t0_r;

  for (genvar k = 0; k < N_TERMS; k++) begin : g_tay
    cwm_taylor_cell #(.K(k + 1)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .tok_i (tay_q[k]),
      .tok_o (tay_q[k+1])
    );
  end

  // stage 5: saturate on a right angle or non-positive cosine; radius * sin
  tay_tok_t         tf;
  logic             cpos;
  logic [A_W-1:0]   us;
  logic [NX_W-1:0]  nx_prod, p5_nx_r;
  logic [UC_W-1:0]  p5_uc_r;
  logic [YQ_W-1:0]  p5_yq_r;
  logic             p5_vld_r, p5_sat_r, p5_aneg_r, p5_hneg_r;

  assign tf      = tay_q[N_TERMS];
  assign cpos    = !tf.c[SUM_W-1] && (tf.c != '0);
  assign us      = tf.s[SUM_W-1] ? '0 : tf.s[A_W-1:0];
  assign nx_prod = radius_r * us;

  // stage 6: divider setup; quotient overflow past QB bits saturates later
  logic [NXS_W-1:0] nxs;
  logic [NY_W-1:0]  nys;
  logic [HX_W-1:0]  hix;
  logic [HY_W-1:0]  hiy;
  div_tok_t         d0_r;

  assign nxs = {p5_nx_r, {FRAC_BITS{1'b0}}};
  assign nys = {p5_yq_r, 14'b0};
  assign hix = nxs[NXS_W-1:QB];
  assign hiy = nys[NY_W-1:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_vld_r <= 1'b0;
      d0_r.vld <= 1'b0;
    end else if (pipe_en) begin
      p5_vld_r  <= tf.vld;
      p5_sat_r  <= tf.big || !cpos;
      p5_aneg_r <= tf.aneg;
      p5_hneg_r <= tf.hneg;
      p5_uc_r   <= tf.c[UC_W-1:0];
      p5_nx_r   <= nx_prod;
      p5_yq_r   <= tf.yq;

      d0_r.vld  <= p5_vld_r;
      d0_r.sat  <= p5_sat_r;
      d0_r.aneg <= p5_aneg_r;
      d0_r.hneg <= p5_hneg_r;
      d0_r.uc   <= p5_uc_r;
      d0_r.ovx  <= HXC_W'(hix) >= HXC_W'(p5_uc_r);
      d0_r.ovy  <= HY_W'(p5_uc_r) <= hiy;
      d0_r.rx   <= UC_W'(hix);
      d0_r.ry   <= UC_W'(hiy);
      d0_r.lx   <= nxs[QB-1:0];
      d0_r.ly   <= nys[QB-1:0];
    end
  end

  // divider cells
  div_tok_t div_q [QB+1];
  assign div_q[0] = d0_r;

  for (genvar i = 0; i < QB; i++) begin : g_div
    cwm_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .tok_i (div_q[i]),
      .tok_o (div_q[i+1])
    );
  end

  // output stage: sign, center, clamp, bounds
  div_tok_t               df;
  logic [QB:0]            xm, ym;
  logic signed [X_W-1:0]  xv, yv;
  logic                   xhi, xlo, yhi, ylo;
  logic signed [OUT_W-1:0] xo, yo;
  logic                   ins;
  logic signed [OUT_W-1:0] out_x_r, out_y_r;
  logic                   out_in_r;

  assign df = div_q[QB];
  assign xm = df.ovx ? (QB+1)'(1) << QB : {1'b0, df.lx};
  assign ym = df.ovy ? (QB+1)'(1) << QB : {1'b0, df.ly};
  assign xv = $signed(X_W'(center_x_r)) +
              (df.aneg ? -$signed(X_W'(xm)) : $signed(X_W'(xm)));
  assign yv = $signed(X_W'(center_y_r)) +
              (df.hneg ? -$signed(X_W'(ym)) : $signed(X_W'(ym)));
  assign xhi = xv > X_W'(OUT_MAX);
  assign xlo = xv < X_W'(OUT_MIN);
  assign yhi = yv > X_W'(OUT_MAX);
  assign ylo = yv < X_W'(OUT_MIN);

  always_comb begin
    if (df.sat) begin
      xo = df.aneg ? OUT_MIN : OUT_MAX;
      yo = df.hneg ? OUT_MIN : OUT_MAX;
    end else begin
      xo = xhi ? OUT_MAX : (xlo ? OUT_MIN : xv[OUT_W-1:0]);
      yo = yhi ? OUT_MAX : (ylo ? OUT_MIN : yv[OUT_W-1:0]);
    end
  end

  assign ins = !df.sat && !xhi && !xlo && !yhi && !ylo &&
               !xv[X_W-1] && !yv[X_W-1] &&
               (xv < $signed(X_W'({src_width_r, {FRAC_BITS{1'b0}}}))) &&
               (yv < $signed(X_W'({src_height_r, {FRAC_BITS{1'b0}}})));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      out_vld_r <= df.vld;
      out_x_r   <= xo;
      out_y_r   <= yo;
      out_in_r  <= ins;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.src_x      = out_x_r;
  assign out_if.src_y      = out_y_r;
  assign out_if.inside_res = out_in_r;

  a_inside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_in_r |-> !out_x_r[OUT_W-1] && !out_y_r[OUT_W-1])
    else $error("inside flag set on a negative coordinate");

  a_sat_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && df.vld && df.sat |=> out_vld_r && !out_in_r)
    else $error("saturated word flagged inside");

endmodule
